// ----- rtl/ces_pkg.sv -----
// ----------------------------------------------------------------------------
// ces_pkg
// Shared types and constants of the clock sync interval estimator.
// ----------------------------------------------------------------------------
package ces_pkg;

   localparam int NowWidth    = 31;
   localparam int StampWidth  = 32;
   localparam int HalfRtWidth = 30;
   localparam int HalfWWidth  = 31;
   localparam int FracBits    = 16;
   localparam int DivBits     = StampWidth + FracBits;
   localparam int DivCntWidth = $clog2(DivBits);
   localparam int ReqDataWidth = 96;
   localparam int RspDataWidth = 128;

   localparam logic [1:0] StatusOk      = 2'd0;
   localparam logic [1:0] StatusInvalid = 2'd1;
   localparam logic [1:0] StatusNoSync  = 2'd2;

   localparam logic KindQuery = 1'b0;
   localparam logic KindSync  = 1'b1;

   // controller -> datapath
   typedef struct packed {
      logic load;
      logic prep1;
      logic prep2;
      logic prep3;
      logic commit;
      logic div_init;
      logic div_step;
      logic finish;
      logic emit;
   } ces_cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic need_div;
      logic div_last;
      logic out_free;
   } ces_stat_type;

endpackage

// ----- rtl/clock_sync_interval_estimator_unit.sv -----
// ----------------------------------------------------------------------------
// clock_sync_interval_estimator_unit
// Interval-intersection estimate of a remote global clock from sync replies.
// ----------------------------------------------------------------------------
// Usage:
//   The req_ channel carries one transaction per sync reply or query; req_tuser
//   selects which (0 query, 1 sync reply). The rsp_ channel returns exactly one
//   result transaction for each request, in order.
//   A sync reply intersects the held global-time window with the reply window
//   and returns the half round trip plus the drift ratio in signed Q16.16.
//   A query returns the projected global time and the window half width.
// Sequencing:
//   One transaction is worked at a time. A query, a rejected sync or a sync
//   with zero shift or zero elapsed time goes from acceptance through the
//   prep, commit and check phases to the output register; a sync that needs a
//   drift ratio also runs the 48-step restoring divider (one quotient bit a
//   cycle). The next request is taken in the cycle after the result is loaded.
// Reset:
//   Synchronous, active high. Clears the estimate (unsynced), drops any
//   pending result and returns the sequencer to idle.
// Stall:
//   A result waits in the output register while rsp_tready is low; the next
//   request is still accepted and worked, then holds before the output
//   register until the waiting result is taken.
// ----------------------------------------------------------------------------
module clock_sync_interval_estimator_unit
   import ces_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_tvalid,
   output logic                    req_tready,
   input  logic                    req_tuser,  // kind
   // [30:0] local_now, [61:31] request_stamp, [93:62] remote_stamp, [95:94] zero
   input  logic [ReqDataWidth-1:0] req_tdata,
   output logic                    rsp_tvalid,
   input  logic                    rsp_tready,
   // [1:0] status, [31:2] half_round_trip, [63:32] drift_ratio,
   // [95:64] global_estimate, [126:96] estimate_half_width, [127] zero
   output logic [RspDataWidth-1:0] rsp_tdata
);

   ces_cmd_type  cmd;
   ces_stat_type stat;

   // sequencer: one phase per cycle unless the emit phase holds, loops on the divider
   ces_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .stat       (stat),
      .cmd        (cmd)
   );

   // window state, arithmetic, divider and output register
   ces_dpath u_dpath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .stat       (stat),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule

// ----- rtl/ces_ctrl.sv -----
// ----------------------------------------------------------------------------
// ces_ctrl
// Sequencer: steps one transaction through the datapath phases.
// ----------------------------------------------------------------------------
module ces_ctrl
   import ces_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  ces_stat_type stat,
   output ces_cmd_type  cmd
);

   typedef enum logic [8:0] {
      S_IDLE   = 9'b000000001,
      S_PREP1  = 9'b000000010,
      S_PREP2  = 9'b000000100,
      S_PREP3  = 9'b000001000,
      S_COMMIT = 9'b000010000,
      S_CHECK  = 9'b000100000,
      S_DIV    = 9'b001000000,
      S_FINISH = 9'b010000000,
      S_EMIT   = 9'b100000000
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      req_tready = 1'b0;
      case (state_ff)
         S_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.load = 1'b1;
               state_in = S_PREP1;
            end
         end
         S_PREP1: begin
            cmd.prep1 = 1'b1;
            state_in  = S_PREP2;
         end
         S_PREP2: begin
            cmd.prep2 = 1'b1;
            state_in  = S_PREP3;
         end
         S_PREP3: begin
            cmd.prep3 = 1'b1;
            state_in  = S_COMMIT;
         end
         S_COMMIT: begin
            cmd.commit = 1'b1;
            state_in   = S_CHECK;
         end
         S_CHECK: begin
            if (stat.need_div) begin
               cmd.div_init = 1'b1;
               state_in     = S_DIV;
            end else begin
               state_in = S_EMIT;
            end
         end
         S_DIV: begin
            cmd.div_step = 1'b1;
            if (stat.div_last) begin
               state_in = S_FINISH;
            end
         end
         S_FINISH: begin
            cmd.finish = 1'b1;
            state_in   = S_EMIT;
         end
         S_EMIT: begin
            // hold until the output register can take the result
            if (stat.out_free) begin
               cmd.emit = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ----- rtl/ces_dpath.sv -----
// ----------------------------------------------------------------------------
// ces_dpath
// Estimator state, window arithmetic, serial drift divider, output register.
// ----------------------------------------------------------------------------
module ces_dpath
   import ces_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  ces_cmd_type             cmd,
   output ces_stat_type            stat,
   input  logic                    req_tuser,
   input  logic [ReqDataWidth-1:0] req_tdata,
   output logic                    rsp_tvalid,
   input  logic                    rsp_tready,
   output logic [RspDataWidth-1:0] rsp_tdata
);

   // captured transaction
   logic                  kind_ff;
   logic [NowWidth-1:0]   now_ff, reqst_ff;
   logic [StampWidth-1:0] remote_ff;

   // estimator state
   logic                  synced_ff, synced_in;
   logic [NowWidth-1:0]   elapsed_ff, elapsed_in;
   logic [StampWidth-1:0] shift_ff, shift_in;
   logic [NowWidth-1:0]   last_ff, last_in;
   logic [StampWidth-1:0] low_ff, low_in;
   logic [StampWidth-1:0] high_ff, high_in;

   // phase scratch
   logic [NowWidth-1:0]   lag_ff;
   logic                  bad_ff, restart_ff;
   logic [StampWidth-1:0] diff_ff;
   logic [HalfWWidth-1:0] hw_ff;
   logic [StampWidth-1:0] low_adv_ff, high_adv_ff;
   logic [StampWidth-1:0] mid_ff, est_ff, reply_high_ff, delta_ff;
   logic                  sync_ok_ff;

   // result
   logic [1:0]             res_status_ff, res_status_in;
   logic [HalfRtWidth-1:0] res_half_ff, res_half_in;
   logic [StampWidth-1:0]  res_drift_ff, res_drift_in;
   logic [StampWidth-1:0]  res_global_ff, res_global_in;
   logic [HalfWWidth-1:0]  res_hw_ff, res_hw_in;

   // divider
   logic [NowWidth-1:0]    div_rem_ff;
   logic [DivBits-1:0]     div_quo_ff;
   logic [NowWidth-1:0]    div_den_ff;
   logic                   div_neg_ff;
   logic [DivCntWidth-1:0] div_cnt_ff;
   logic [NowWidth+1:0]    div_trial;
   logic [StampWidth-1:0]  div_mag;

   // output register
   logic                    out_valid_ff;
   logic [RspDataWidth-1:0] out_data_ff;

   logic [StampWidth:0] diff_wide;
   logic [StampWidth:0] lag_wide;
   logic                est_out;

   assign diff_wide = {2'b00, now_ff} - {2'b00, last_ff};
   assign lag_wide  = {2'b00, now_ff} - {2'b00, reqst_ff};
   assign div_trial = {1'b0, div_rem_ff, div_quo_ff[DivBits-1]} - {2'b00, div_den_ff};
   assign div_mag   = shift_ff[StampWidth-1] ? (~shift_ff + 1'b1) : shift_ff;
   assign est_out   = ($signed(est_ff) < $signed(low_adv_ff))
                   || ($signed(est_ff) > $signed(high_adv_ff));

   assign stat.need_div = sync_ok_ff && (shift_ff != '0) && (elapsed_ff != '0);
   assign stat.div_last = (div_cnt_ff == DivCntWidth'(DivBits - 1));
   assign stat.out_free = !out_valid_ff || rsp_tready;

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;

   always_comb begin
      synced_in     = synced_ff;
      elapsed_in    = elapsed_ff;
      shift_in      = shift_ff;
      last_in       = last_ff;
      low_in        = low_ff;
      high_in       = high_ff;
      res_status_in = res_status_ff;
      res_half_in   = res_half_ff;
      res_drift_in  = res_drift_ff;
      res_global_in = res_global_ff;
      res_hw_in     = res_hw_ff;
      if (cmd.commit) begin
         res_status_in = StatusOk;
         res_half_in   = '0;
         res_drift_in  = '0;
         res_global_in = '0;
         res_hw_in     = '0;
         if (kind_ff == KindQuery) begin
            if (!synced_ff) begin
               res_status_in = StatusNoSync;
            end else begin
               res_global_in = mid_ff;
               res_hw_in     = hw_ff;
            end
         end else if (bad_ff) begin
            res_status_in = StatusInvalid;
         end else begin
            res_half_in = lag_ff[NowWidth-1:1];
            last_in     = now_ff;
            synced_in   = 1'b1;
            if (restart_ff) begin
               elapsed_in = '0;
               shift_in   = '0;
               low_in     = remote_ff;
               high_in    = reply_high_ff;
            end else begin
               elapsed_in = elapsed_ff + diff_ff[NowWidth-1:0];
               shift_in   = shift_ff + delta_ff;
               if (est_out) begin
                  low_in  = remote_ff;
                  high_in = reply_high_ff;
               end else begin
                  low_in  = ($signed(remote_ff) > $signed(low_adv_ff)) ? remote_ff
                                                                       : low_adv_ff;
                  high_in = ($signed(reply_high_ff) < $signed(high_adv_ff))
                            ? reply_high_ff : high_adv_ff;
               end
            end
         end
      end
      if (cmd.finish) begin
         // saturate the truncated quotient to signed 32 bits
         if (div_neg_ff) begin
            if ((div_quo_ff[DivBits-1:StampWidth] != '0)
                || (div_quo_ff[StampWidth-1] && (div_quo_ff[StampWidth-2:0] != '0))) begin
               res_drift_in = {1'b1, {(StampWidth-1){1'b0}}};
            end else begin
               res_drift_in = ~div_quo_ff[StampWidth-1:0] + 1'b1;
            end
         end else begin
            if (div_quo_ff[DivBits-1:StampWidth-1] != '0) begin
               res_drift_in = {1'b0, {(StampWidth-1){1'b1}}};
            end else begin
               res_drift_in = div_quo_ff[StampWidth-1:0];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         synced_ff    <= 1'b0;
         elapsed_ff   <= '0;
         shift_ff     <= '0;
         last_ff      <= '0;
         low_ff       <= '0;
         high_ff      <= '0;
         out_valid_ff <= 1'b0;
         sync_ok_ff   <= 1'b0;
         div_cnt_ff   <= '0;
      end else begin
         synced_ff  <= synced_in;
         elapsed_ff <= elapsed_in;
         shift_ff   <= shift_in;
         last_ff    <= last_in;
         low_ff     <= low_in;
         high_ff    <= high_in;
         if (cmd.commit) begin
            sync_ok_ff <= (kind_ff == KindSync) && !bad_ff;
         end
         if (cmd.div_init) begin
            div_cnt_ff <= '0;
         end else if (cmd.div_step) begin
            div_cnt_ff <= div_cnt_ff + 1'b1;
         end
         if (cmd.emit) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      res_status_ff <= res_status_in;
      res_half_ff   <= res_half_in;
      res_drift_ff  <= res_drift_in;
      res_global_ff <= res_global_in;
      res_hw_ff     <= res_hw_in;
      if (cmd.load) begin
         kind_ff   <= req_tuser;
         now_ff    <= req_tdata[NowWidth-1:0];
         reqst_ff  <= req_tdata[2*NowWidth-1:NowWidth];
         remote_ff <= req_tdata[2*NowWidth+StampWidth-1:2*NowWidth];
      end
      if (cmd.prep1) begin
         lag_ff      <= lag_wide[NowWidth-1:0];
         bad_ff      <= now_ff < reqst_ff;
         restart_ff  <= !synced_ff || (now_ff < last_ff);
         diff_ff     <= diff_wide[StampWidth-1:0];
         hw_ff       <= HalfWWidth'((high_ff - low_ff) >> 1);
         low_adv_ff  <= low_ff + diff_wide[StampWidth-1:0];
         high_adv_ff <= high_ff + diff_wide[StampWidth-1:0];
      end
      if (cmd.prep2) begin
         mid_ff        <= low_adv_ff + {1'b0, hw_ff};
         est_ff        <= remote_ff + {2'b00, lag_ff[NowWidth-1:1]};
         reply_high_ff <= remote_ff + {1'b0, lag_ff};
      end
      if (cmd.prep3) begin
         delta_ff <= est_ff - mid_ff;
      end
      if (cmd.div_init) begin
         div_rem_ff <= '0;
         div_quo_ff <= {div_mag, {FracBits{1'b0}}};
         div_den_ff <= elapsed_ff;
         div_neg_ff <= shift_ff[StampWidth-1];
      end else if (cmd.div_step) begin
         div_rem_ff <= div_trial[NowWidth+1] ? {div_rem_ff[NowWidth-2:0],
                                                div_quo_ff[DivBits-1]}
                                             : div_trial[NowWidth-1:0];
         div_quo_ff <= {div_quo_ff[DivBits-2:0], ~div_trial[NowWidth+1]};
      end
      if (cmd.emit) begin
         out_data_ff <= {1'b0, res_hw_ff, res_global_ff, res_drift_ff,
                         res_half_ff, res_status_ff};
      end
   end

   // a finished result never overwrites one the receiver has not taken
   a_emit_free: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> (!out_valid_ff || rsp_tready))
      else $error("result register overwritten");

   // before the first sync the accumulators stay cleared
   a_unsynced_clear: assert property (@(posedge clock) disable iff (reset)
      !synced_ff |-> (shift_ff == '0) && (elapsed_ff == '0))
      else $error("accumulators moved before first sync");

   // the divider only runs against a nonzero divisor
   a_div_den: assert property (@(posedge clock) disable iff (reset)
      cmd.div_step |-> (div_den_ff != '0))
      else $error("drift division by zero");

   // the quotient is used only after all bit steps
   a_div_finish: assert property (@(posedge clock) disable iff (reset)
      cmd.finish |-> $past(cmd.div_step && stat.div_last))
      else $error("drift quotient taken early");

endmodule
